/* hw/rtl/mbe_pkg.sv */
// shared types, constants and saturating helpers for the escape-time block
// used by mbe_mac and mandelbrot_escape_time; no dependencies
package mbe_pkg;

	localparam int FRACTION_BITS = 42;
	localparam int COORD_BITS    = 12;

	localparam int VAL_W     = 48;
	localparam int STEP_W    = 47;
	localparam int HALF_W    = 24;
	localparam int PROD_W    = 2 * HALF_W;
	localparam int ACC_W     = (FRACTION_BITS + VAL_W > 96) ? FRACTION_BITS + VAL_W : 96;
	localparam int ITER_W    = 16;
	localparam int PAL_W     = 9;
	localparam int PIDX_W    = 8;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [VAL_W-1:0]        mag_t;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< FRACTION_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE  = 3'd5;

	localparam val_t               ORIGIN_X_RST = -48'sd10995116277760;
	localparam val_t               ORIGIN_Y_RST = -48'sd6597069766656;
	localparam logic [STEP_W-1:0]  STEP_RST     = 47'd4294967296;
	localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;
	localparam logic [PAL_W-1:0]   PALETTE_RST  = 9'd256;

	localparam logic [1:0] SH_NONE    = 2'd0;
	localparam logic [1:0] SH_HALF    = 2'd1;
	localparam logic [1:0] SH_HALF_X2 = 2'd2;
	localparam logic [1:0] SH_FULL    = 2'd3;

	localparam logic [2:0] DST_CX = 3'd0;
	localparam logic [2:0] DST_CY = 3'd1;
	localparam logic [2:0] DST_XX = 3'd2;
	localparam logic [2:0] DST_YY = 3'd3;
	localparam logic [2:0] DST_W  = 3'd4;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic [1:0] shift;
		logic [2:0] dst;
	} mac_tag_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] dst;
		val_t       data;
	} mac_wr_t;

	function automatic val_t sat_add(val_t a, val_t b);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
		end else begin
			sat_add = s[VAL_W-1:0];
		end
	endfunction

	function automatic val_t sat_sub(val_t a, val_t b);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1]) begin
			sat_sub = s[VAL_W] ? VAL_MIN : VAL_MAX;
		end else begin
			sat_sub = s[VAL_W-1:0];
		end
	endfunction

	function automatic mag_t mag(val_t v);
		mag = v[VAL_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

/* hw/rtl/mandelbrot_escape_time.sv */
// top level of the escape-time evaluator: sequencer, registers, result strobe
// depends on mbe_pkg and mbe_mac
//
// usage:
//   config: cfg_valid/cfg_ready write channel, cfg_index selects origin_x,
//   origin_y, step_x, step_y, max_iterations, palette_size (0..5); other
//   indexes are ignored. cfg_ready is always high. write only while idle.
//   request: pulse start with pixel_col/pixel_row while busy is low.
//   the pixel maps to c = origin + index*step in signed Q6.42 and z = z^2 + c
//   runs from z = 0 until the limit is reached or |z|^2 exceeds 4.
//   result: done is high for one cycle with iteration_count, escaped and
//   palette_index; the receiver cannot stall, so nothing waits on it.
//   sequence: the coordinates are formed first, then each iteration runs the
//   add states, the passes through the single 24x24 multiplier (three squares
//   of three partial products each), a test and a wait that lets the last
//   product land; done rises after the test that stops. busy drops in the done
//   cycle, so the next request can be taken right then; no new request is
//   taken while busy.
//   reset: config registers go to their defaults, the block is idle, no result.
module mandelbrot_escape_time (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [mbe_pkg::COORD_BITS-1:0]   pixel_col,
	input  logic [mbe_pkg::COORD_BITS-1:0]   pixel_row,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbe_pkg::VAL_W-1:0]        cfg_data,
	output logic                             done,
	output logic [mbe_pkg::ITER_W-1:0]       iteration_count,
	output logic                             escaped,
	output logic [mbe_pkg::PIDX_W-1:0]       palette_index
);
	import mbe_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COORD = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_ADD1  = 3'd3;
	localparam logic [2:0] S_ADD2  = 3'd4;
	localparam logic [2:0] S_ADD3  = 3'd5;
	localparam logic [2:0] S_MUL   = 3'd6;
	localparam logic [2:0] S_TEST  = 3'd7;

	logic [2:0]            state_q;
	logic [1:0]            part_q;
	logic [1:0]            sq_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;

	val_t                  origin_x_q;
	val_t                  origin_y_q;
	logic [STEP_W-1:0]     step_x_q;
	logic [STEP_W-1:0]     step_y_q;
	logic [ITER_W-1:0]     max_iter_q;
	logic [PAL_W-1:0]      pal_q;

	val_t                  cx_q, cy_q, xx_q, yy_q, w_q, ss_q;
	val_t                  d1_q, d2_q, x1_q, y1_q, s_q;
	mag_t                  mx_q, my_q, ms_q;
	logic [ITER_W-1:0]     iter_q;
	logic [PAL_W-1:0]      rem_q;

	logic                  done_q;
	logic [ITER_W-1:0]     count_out_q;
	logic                  esc_out_q;
	logic [PIDX_W-1:0]     pidx_out_q;

	logic                  accept;
	logic [ITER_W-1:0]     count_next;
	logic [PAL_W-1:0]      rem_inc;
	logic [PAL_W-1:0]      rem_next;
	val_t                  ss_next;
	logic signed [63:0]    ss_wide;
	logic                  hit_limit;
	logic                  esc_hit;
	logic                  stop;

	mac_tag_t              tag;
	logic [HALF_W-1:0]     op_a;
	logic [HALF_W-1:0]     op_b;
	mac_wr_t               wr;
	logic [COORD_BITS-1:0] coord_idx;
	logic [STEP_W-1:0]     coord_step;
	mag_t                  sq_mag;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign done            = done_q;
	assign iteration_count = count_out_q;
	assign escaped         = esc_out_q;
	assign palette_index   = pidx_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= ORIGIN_X_RST;
			origin_y_q <= ORIGIN_Y_RST;
			step_x_q   <= STEP_RST;
			step_y_q   <= STEP_RST;
			max_iter_q <= MAX_ITER_RST;
			pal_q      <= PALETTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_STEP_X:   step_x_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:   step_y_q   <= cfg_data[STEP_W-1:0];
				REG_MAX_ITER: max_iter_q <= cfg_data[ITER_W-1:0];
				REG_PALETTE:  pal_q      <= cfg_data[PAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		count_next = iter_q + 1'b1;
		rem_inc    = rem_q + 1'b1;
		rem_next   = (rem_inc == pal_q) ? '0 : rem_inc;
		ss_next    = sat_add(xx_q, yy_q);
		ss_wide    = 64'(ss_next);
		hit_limit  = (count_next >= max_iter_q);
		esc_hit    = (ss_wide > ESC_LIMIT);
		stop       = hit_limit || esc_hit;
	end

	// operand and tag selection for the shared multiplier
	always_comb begin
		coord_idx  = sq_q[0] ? row_q : col_q;
		coord_step = sq_q[0] ? step_y_q : step_x_q;
		case (sq_q)
			2'd0:    sq_mag = mx_q;
			2'd1:    sq_mag = my_q;
			default: sq_mag = ms_q;
		endcase
		tag  = '0;
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_COORD: begin
				tag.valid = 1'b1;
				tag.first = !part_q[0];
				tag.last  = part_q[0];
				tag.shift = part_q[0] ? SH_HALF : SH_NONE;
				tag.dst   = sq_q[0] ? DST_CY : DST_CX;
				op_a      = HALF_W'(coord_idx);
				op_b      = part_q[0] ? HALF_W'(coord_step[STEP_W-1:HALF_W])
				                      : coord_step[HALF_W-1:0];
			end
			S_MUL: begin
				tag.valid = 1'b1;
				case (sq_q)
					2'd0:    tag.dst = DST_XX;
					2'd1:    tag.dst = DST_YY;
					default: tag.dst = DST_W;
				endcase
				case (part_q)
					2'd0: begin
						tag.first = 1'b1;
						tag.shift = SH_NONE;
						op_a      = sq_mag[HALF_W-1:0];
						op_b      = sq_mag[HALF_W-1:0];
					end
					2'd1: begin
						tag.shift = SH_HALF_X2;
						op_a      = sq_mag[VAL_W-1:HALF_W];
						op_b      = sq_mag[HALF_W-1:0];
					end
					default: begin
						tag.last  = 1'b1;
						tag.shift = SH_FULL;
						op_a      = sq_mag[VAL_W-1:HALF_W];
						op_b      = sq_mag[VAL_W-1:HALF_W];
					end
				endcase
			end
			default: ;
		endcase
	end

	mbe_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag      (tag),
		.op_a     (op_a),
		.op_b     (op_b),
		.origin_x (origin_x_q),
		.origin_y (origin_y_q),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q  <= '0;
			sq_q    <= '0;
			iter_q  <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						part_q  <= '0;
						sq_q    <= '0;
						iter_q  <= '0;
						rem_q   <= '0;
						state_q <= S_COORD;
					end
				end
				S_COORD: begin
					if (part_q[0]) begin
						part_q <= '0;
						if (sq_q[0]) begin
							sq_q    <= '0;
							state_q <= S_WAIT;
						end else begin
							sq_q <= 2'd1;
						end
					end else begin
						part_q <= 2'd1;
					end
				end
				S_WAIT: state_q <= S_ADD1;
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: state_q <= S_ADD3;
				S_ADD3: begin
					part_q  <= '0;
					sq_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (part_q == 2'd2) begin
						part_q <= '0;
						if (sq_q == 2'd2) begin
							sq_q    <= '0;
							state_q <= S_TEST;
						end else begin
							sq_q <= sq_q + 1'b1;
						end
					end else begin
						part_q <= part_q + 1'b1;
					end
				end
				S_TEST: begin
					iter_q <= count_next;
					rem_q  <= rem_next;
					if (stop) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// iterate registers: xx, yy, w and ss cleared per request; c and squares loaded from the mac, ss in the test state
	always_ff @(posedge clk) begin
		if (accept) begin
			xx_q <= '0;
			yy_q <= '0;
			w_q  <= '0;
			ss_q <= '0;
		end else begin
			if (wr.valid) begin
				case (wr.dst)
					DST_CX:  cx_q <= wr.data;
					DST_CY:  cy_q <= wr.data;
					DST_XX:  xx_q <= wr.data;
					DST_YY:  yy_q <= wr.data;
					DST_W:   w_q  <= wr.data;
					default: ;
				endcase
			end
			if (state_q == S_TEST) begin
				ss_q <= ss_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		case (state_q)
			S_ADD1: begin
				d1_q <= sat_sub(xx_q, yy_q);
				d2_q <= sat_sub(w_q, ss_q);
			end
			S_ADD2: begin
				x1_q <= sat_add(d1_q, cx_q);
				y1_q <= sat_add(d2_q, cy_q);
			end
			S_ADD3: begin
				s_q  <= sat_add(x1_q, y1_q);
				mx_q <= mag(x1_q);
				my_q <= mag(y1_q);
			end
			S_MUL: ms_q <= mag(s_q);
			S_TEST: begin
				if (stop) begin
					count_out_q <= count_next;
					esc_out_q   <= !hit_limit;
					pidx_out_q  <= (!hit_limit && (pal_q != '0)) ? rem_next[PIDX_W-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && escaped) |-> (iteration_count < max_iter_q))
		else $error("escaped result at or above the iteration limit");

	a_inside_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !escaped) |-> (palette_index == '0))
		else $error("nonzero palette index for an inside point");

endmodule

/* hw/rtl/mbe_mac.sv */
// shared 24x24 multiply-accumulate unit with square and coordinate finishing
// depends on mbe_pkg
module mbe_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  mbe_pkg::mac_tag_t tag,
	input  logic [mbe_pkg::HALF_W-1:0] op_a,
	input  logic [mbe_pkg::HALF_W-1:0] op_b,
	input  mbe_pkg::val_t    origin_x,
	input  mbe_pkg::val_t    origin_y,
	output mbe_pkg::mac_wr_t wr
);
	import mbe_pkg::*;

	logic [PROD_W-1:0] prod_s1;
	mac_tag_t          tag_s1;
	mac_tag_t          tag_s2;
	logic [ACC_W-1:0]  acc_s2;
	logic [ACC_W-1:0]  term;
	logic [ACC_W-1:0]  acc_sum;
	logic              sq_ovf;
	val_t              sq_val;
	logic              p_big;
	logic [VAL_W:0]    p_cap;
	val_t              origin;
	logic [VAL_W+1:0]  csum;
	val_t              coord_val;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_comb begin
		case (tag_s1.shift)
			SH_NONE:    term = ACC_W'(prod_s1);
			SH_HALF:    term = ACC_W'(prod_s1) << HALF_W;
			SH_HALF_X2: term = ACC_W'(prod_s1) << (HALF_W + 1);
			SH_FULL:    term = ACC_W'(prod_s1) << (2 * HALF_W);
			default:    term = '0;
		endcase
		acc_sum = (tag_s1.first ? '0 : acc_s2) + term;
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			acc_s2 <= acc_sum;
		end
	end

	// square: drop fraction bits, clamp to the positive limit
	always_comb begin
		sq_ovf = |acc_s2[ACC_W-1:FRACTION_BITS+VAL_W-1];
		sq_val = sq_ovf ? VAL_MAX : {1'b0, acc_s2[FRACTION_BITS+VAL_W-2:FRACTION_BITS]};
	end

	// coordinate: cap index*step, add origin, saturate
	always_comb begin
		p_big  = (|acc_s2[ACC_W-1:VAL_W+1]) || (acc_s2[VAL_W] && (|acc_s2[VAL_W-1:0]));
		p_cap  = p_big ? {1'b1, {VAL_W{1'b0}}} : acc_s2[VAL_W:0];
		origin = (tag_s2.dst == DST_CY) ? origin_y : origin_x;
		csum   = {{2{origin[VAL_W-1]}}, origin} + {1'b0, p_cap};
		if ((csum[VAL_W+1] == csum[VAL_W]) && (csum[VAL_W] == csum[VAL_W-1])) begin
			coord_val = csum[VAL_W-1:0];
		end else begin
			coord_val = csum[VAL_W+1] ? VAL_MIN : VAL_MAX;
		end
	end

	always_comb begin
		wr.valid = tag_s2.valid && tag_s2.last;
		wr.dst   = tag_s2.dst;
		wr.data  = ((tag_s2.dst == DST_CX) || (tag_s2.dst == DST_CY)) ? coord_val : sq_val;
	end

endmodule

/* tb/mandelbrot_escape_time_tb.sv */
// self-checking testbench for mandelbrot_escape_time: pixel requests, register writes, results
// predicts every result with a fixed-point escape-time model kept in a small scoreboard class
// depends on mbe_pkg and the escape-time RTL
module mandelbrot_escape_time_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam val_t                 QUARTER       = val_t'(64'd1 << 40);
	localparam logic [STEP_W-1:0]    STEP_MAX      = '1;

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [ITER_W-1:0]     count;
		logic                  escaped;
		logic [PIDX_W-1:0]     pidx;
	} escape_result_t;

	class pixel_ledger;
		val_t              org_x;
		val_t              org_y;
		logic [STEP_W-1:0] stp_x;
		logic [STEP_W-1:0] stp_y;
		logic [ITER_W-1:0] iter_limit;
		logic [PAL_W-1:0]  wrap_len;
		escape_result_t    due_pixels[$];
		int unsigned       errors;
		int unsigned       checked;

		function new();
			org_x      = ORIGIN_X_RST;
			org_y      = ORIGIN_Y_RST;
			stp_x      = STEP_RST;
			stp_y      = STEP_RST;
			iter_limit = MAX_ITER_RST;
			wrap_len   = PALETTE_RST;
			errors     = 0;
			checked    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
			case (idx)
			REG_ORIGIN_X: org_x = data;
			REG_ORIGIN_Y: org_y = data;
			REG_STEP_X:   stp_x = data[STEP_W-1:0];
			REG_STEP_Y:   stp_y = data[STEP_W-1:0];
			REG_MAX_ITER: iter_limit = data[ITER_W-1:0];
			REG_PALETTE:  wrap_len = data[PAL_W-1:0];
			default: ;
			endcase
		endfunction

		function val_t sat_q(longint v);
			if (v > longint'(VAL_MAX)) return VAL_MAX;
			if (v < longint'(VAL_MIN)) return VAL_MIN;
			return val_t'(v);
		endfunction

		function val_t square_trunc(val_t v);
			logic [VAL_W-1:0]   a;
			logic [2*VAL_W-1:0] p;
			a = v[VAL_W-1] ? -v : v;
			p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, a};
			p = p >> FRACTION_BITS;
			if (p > (2*VAL_W)'(longint'(VAL_MAX))) return VAL_MAX;
			return val_t'(p[VAL_W-1:0]);
		endfunction

		function val_t grid_coord(val_t origin, logic [STEP_W-1:0] step,
				logic [COORD_BITS-1:0] idx);
			logic [63:0] p;
			p = 64'(idx) * 64'(step);
			if (p > (64'd1 << 48)) p = 64'd1 << 48;
			return sat_q(longint'(origin) + longint'(p));
		endfunction

		function escape_result_t escape_time(logic [COORD_BITS-1:0] col,
				logic [COORD_BITS-1:0] row);
			val_t           cx, cy, x1, y1, xx, yy, ss, w;
			int unsigned    count;
			bit             running;
			escape_result_t r;
			cx = grid_coord(org_x, stp_x, col);
			cy = grid_coord(org_y, stp_y, row);
			xx = '0;
			yy = '0;
			ss = '0;
			w = '0;
			count = 0;
			running = 1'b1;
			while (running) begin
				x1 = sat_q(longint'(sat_q(longint'(xx) - longint'(yy))) + longint'(cx));
				y1 = sat_q(longint'(sat_q(longint'(w) - longint'(ss))) + longint'(cy));
				xx = square_trunc(x1);
				yy = square_trunc(y1);
				// 2xy comes from (x+y)^2 - x^2 - y^2
				w = square_trunc(sat_q(longint'(x1) + longint'(y1)));
				count++;
				if (count >= iter_limit) begin
					running = 1'b0;
				end else begin
					ss = sat_q(longint'(xx) + longint'(yy));
					if (longint'(ss) > longint'(ESC_LIMIT)) running = 1'b0;
				end
			end
			r.col = col;
			r.row = row;
			r.count = count[ITER_W-1:0];
			r.escaped = count < iter_limit;
			r.pidx = (r.escaped && wrap_len != 0) ? PIDX_W'(count % wrap_len) : '0;
			return r;
		endfunction

		function void take_request(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
			due_pixels.push_back(escape_time(col, row));
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pixel(logic [ITER_W-1:0] count, logic esc, logic [PIDX_W-1:0] pidx);
			escape_result_t want;
			checked++;
			if (due_pixels.size() == 0) begin
				report_mismatch($sformatf("result with no request pending, count %0d", count));
				return;
			end
			want = due_pixels.pop_front();
			if (count !== want.count)
				report_mismatch($sformatf("pixel (%0d,%0d) iteration_count %0d, want %0d",
					want.col, want.row, count, want.count));
			if (esc !== want.escaped)
				report_mismatch($sformatf("pixel (%0d,%0d) escaped %b, want %b",
					want.col, want.row, esc, want.escaped));
			if (pidx !== want.pidx)
				report_mismatch($sformatf("pixel (%0d,%0d) palette_index %0d, want %0d",
					want.col, want.row, pidx, want.pidx));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [COORD_BITS-1:0] pixel_col = '0;
	logic [COORD_BITS-1:0] pixel_row = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [VAL_W-1:0]      cfg_data = '0;
	logic                  done;
	logic [ITER_W-1:0]     iteration_count;
	logic                  escaped;
	logic [PIDX_W-1:0]     palette_index;

	pixel_ledger ledger;
	int unsigned idle_pct = 0;
	int unsigned requests = 0;
	int unsigned settings = 0;

	mandelbrot_escape_time dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.iteration_count (iteration_count),
		.escaped         (escaped),
		.palette_index   (palette_index)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (done) ledger.check_pixel(iteration_count, escaped, palette_index);
	end

	function automatic logic [COORD_BITS-1:0] pick_index();
		case ($urandom_range(0, 15))
		0: return '0;
		1: return '1;
		default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic val_t pick_origin();
		case ($urandom_range(0, 2))
		0: return VAL_MIN;
		1: return VAL_MAX;
		default: return VAL_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 2))
		0: return '0;
		1: return STEP_MAX;
		default: return STEP_W'({$urandom, $urandom});
		endcase
	endfunction

	task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		pixel_col <= col;
		pixel_row <= row;
		do @(posedge clk); while (busy);
		ledger.take_request(col, row);
		requests++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (ledger.due_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_register(idx, data);
	endtask

	// unused upper data bits get random values, the block must drop them
	task automatic apply_settings(input val_t ox, input val_t oy,
			input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
			input logic [ITER_W-1:0] lim, input logic [PAL_W-1:0] pal);
		wait_idle();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_STEP_X, {1'($urandom), sx});
		write_reg(REG_STEP_Y, {1'($urandom), sy});
		write_reg(REG_MAX_ITER, {32'($urandom), lim});
		write_reg(REG_PALETTE, {39'({$urandom, $urandom}), pal});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		int                view;
		val_t              ox, oy;
		logic [STEP_W-1:0] sx, sy;
		logic [ITER_W-1:0] lim;
		logic [PAL_W-1:0]  pal;

		ledger = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: corners, points inside, c = -2 sits exactly on the escape bound
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd1536);
		send_pixel(12'd512, 12'd1536);
		send_pixel(12'd2816, 12'd1536);

		wait_idle();
		write_reg(REG_UNUSED_LO, VAL_W'({$urandom, $urandom}));
		write_reg(REG_UNUSED_HI, VAL_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
		send_pixel(12'd1024, 12'd1024);

		// zero limit, then a limit of one that wins over an escape, then a zero palette
		apply_settings(ORIGIN_X_RST, ORIGIN_Y_RST, STEP_RST, STEP_RST, 16'd0, PALETTE_RST);
		send_pixel(12'd2048, 12'd1536);
		apply_settings(ORIGIN_X_RST, ORIGIN_Y_RST, STEP_RST, STEP_RST, 16'd1, PALETTE_RST);
		send_pixel(12'd0, 12'd0);
		apply_settings(ORIGIN_X_RST, ORIGIN_Y_RST, STEP_RST, STEP_RST, 16'd40, 9'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1500, 12'd2000);

		// slow escapes right of the cusp, some with counts above 256
		apply_settings(QUARTER, '0, STEP_W'(1) << 22, '0, 16'd600, 9'd511);
		send_pixel(12'd60, 12'd0);
		send_pixel(12'd100, 12'd0);
		send_pixel(12'd4095, 12'd0);
		apply_settings(QUARTER, '0, STEP_W'(1) << 22, '0, 16'd600, 9'd1);
		send_pixel(12'd2000, 12'd0);

		// saturated origins and capped products
		apply_settings(VAL_MAX, VAL_MIN, STEP_MAX, '0, 16'hFFFF, 9'd256);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd4095);
		apply_settings(VAL_MIN, VAL_MIN, STEP_MAX, '0, 16'hFFFF, 9'd256);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2, 12'd0);
		send_pixel(12'd1, 12'd0);

		for (int p = 0; p < 16; p++) begin
			view = p % 4;
			case (view)
			0: begin
				ox = ORIGIN_X_RST;
				oy = ORIGIN_Y_RST;
				sx = STEP_RST;
				sy = STEP_RST;
			end
			1: begin
				ox = QUARTER;
				oy = '0;
				sx = STEP_W'($urandom_range(1 << 21, 1 << 23));
				sy = STEP_W'($urandom_range(0, 1 << 20));
			end
			2: begin
				ox = ORIGIN_X_RST + val_t'({12'($urandom), $urandom});
				oy = ORIGIN_Y_RST + val_t'({12'($urandom), $urandom});
				sx = STEP_W'({2'($urandom), $urandom});
				sy = STEP_W'({2'($urandom), $urandom});
			end
			default: begin
				ox = pick_origin();
				oy = pick_origin();
				sx = pick_step();
				sy = pick_step();
			end
			endcase
			if (view == 1) lim = 16'd600;
			else if (p == 0 || p == 12) lim = 16'd256;
			else if (p % 5 == 3) lim = ITER_W'($urandom_range(0, 3));
			else lim = ITER_W'($urandom_range(1, 40));
			if (view == 1) begin
				pal = PAL_W'($urandom_range(257, 511));
			end else if (view == 0) begin
				case ($urandom_range(0, 3))
				0: pal = 9'd0;
				1: pal = 9'd1;
				2: pal = 9'd256;
				default: pal = 9'd511;
				endcase
			end else begin
				pal = PAL_W'($urandom_range(0, 511));
			end
			apply_settings(ox, oy, sx, sy, lim, pal);
			idle_pct = (p % 3 == 1) ? 53 : (p % 3 == 2) ? 15 : 0;
			repeat ((view == 1) ? 40 : 120) send_pixel(pick_index(), pick_index());
		end

		wait_idle();
		repeat (100) @(posedge clk);
		$display("%0d pixel requests over %0d register settings, %0d results checked",
			requests, settings, ledger.checked);
		$display("limits 0 to 65535, palettes 0 to 511, saturated origins and steps");
		if (ledger.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#300_000_000;
		$display("timeout with %0d results outstanding", ledger.due_pixels.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
